// ----- src/slas_pkg.sv -----
// ----------------------------------------------------------------------------
// slas_pkg
// Shared types, constants and geometry tables of the leg angle stepper.
// ----------------------------------------------------------------------------
package slas_pkg;

    localparam int LEG_COUNT        = 6;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ADDR_W           = 5;

    // command codes
    localparam logic [1:0] CMD_HOME  = 2'd0;
    localparam logic [1:0] CMD_PITCH = 2'd1;
    localparam logic [1:0] CMD_ROLL  = 2'd2;

    // status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_DRASTIC = 3'd1;
    localparam logic [2:0] STAT_LOW     = 3'd2;
    localparam logic [2:0] STAT_HIGH    = 3'd3;
    localparam logic [2:0] STAT_UNREACH = 3'd4;

    // register indexes
    localparam logic [2:0] REG_LOW    = 3'd0;
    localparam logic [2:0] REG_HIGH   = 3'd1;
    localparam logic [2:0] REG_MOVE   = 3'd2;
    localparam logic [2:0] REG_FINE   = 3'd3;
    localparam logic [2:0] REG_COARSE = 3'd4;

    localparam logic [15:0] LOW_RST    = 16'd6554;
    localparam logic [15:0] HIGH_RST   = 16'd58982;
    localparam logic [15:0] MOVE_RST   = 16'd13107;
    localparam logic [11:0] FINE_RST   = 12'd286;
    localparam logic [11:0] COARSE_RST = 12'd858;
    localparam logic [15:0] MID_POS    = 16'd32768;

    // Q30 angles and lengths in Q16 mm
    localparam logic signed [39:0] Q30_PI      = 40'sd3373259426;
    localparam logic signed [39:0] Q30_HALF_PI = 40'sd1686629713;
    localparam logic signed [39:0] CORDIC_KINV = 40'sd652032874;
    localparam logic signed [35:0] HOME_Z      = 36'sd9568256;
    localparam logic signed [35:0] TWO_HORN    = 36'sd3247964;
    localparam logic signed [35:0] PLAT_Z      = -36'sd622592;
    localparam logic signed [35:0] POS_MUL     = 36'sd21361415;
    localparam logic signed [63:0] ROD_Q16     = 64'sd9502720;
    localparam logic signed [63:0] HORN_Q16    = 64'sd1623982;
    localparam logic signed [63:0] LEG_SQ      = ROD_Q16 * ROD_Q16 - HORN_Q16 * HORN_Q16;
    localparam logic signed [63:0] POS_ROUND   = 64'sd549755813888;

    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_ctl;

    function automatic logic signed [39:0] atan_entry(input logic [4:0] idx);
        logic signed [39:0] v;
        case (idx)
            5'd0:  v = 40'sh3243F6A8;
            5'd1:  v = 40'sh1DAC6705;
            5'd2:  v = 40'sh0FADBAFC;
            5'd3:  v = 40'sh07F56EA6;
            5'd4:  v = 40'sh03FEAB76;
            5'd5:  v = 40'sh01FFD55B;
            5'd6:  v = 40'sh00FFFAAA;
            5'd7:  v = 40'sh007FFF55;
            5'd8:  v = 40'sh003FFFEA;
            5'd9:  v = 40'sh001FFFFD;
            5'd10: v = 40'sh000FFFFF;
            5'd11: v = 40'sh0007FFFF;
            5'd12: v = 40'sh0003FFFF;
            5'd13: v = 40'sh0001FFFF;
            5'd14: v = 40'sh0000FFFF;
            5'd15: v = 40'sh00007FFF;
            5'd16: v = 40'sh00003FFF;
            5'd17: v = 40'sh00001FFF;
            5'd18: v = 40'sh00000FFF;
            5'd19: v = 40'sh000007FF;
            5'd20: v = 40'sh000003FF;
            5'd21: v = 40'sh000001FF;
            5'd22: v = 40'sh000000FF;
            5'd23: v = 40'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [35:0] base_x(input logic [2:0] leg);
        logic signed [35:0] v;
        case (leg)
            3'd1, 3'd2: v = 36'sd4043571;
            3'd4, 3'd5: v = -36'sd4043571;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [35:0] base_y(input logic [2:0] leg);
        logic signed [35:0] v;
        case (leg)
            3'd0:       v = -36'sd4669440;
            3'd1, 3'd5: v = -36'sd2334720;
            3'd2, 3'd4: v = 36'sd2334720;
            3'd3:       v = 36'sd4669440;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [35:0] plat_x(input logic [2:0] leg);
        logic signed [35:0] v;
        case (leg)
            3'd1, 3'd2: v = 36'sd1702625;
            3'd4, 3'd5: v = -36'sd1702625;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [35:0] plat_y(input logic [2:0] leg);
        logic signed [35:0] v;
        case (leg)
            3'd0:       v = -36'sd1966080;
            3'd1, 3'd5: v = -36'sd983040;
            3'd2, 3'd4: v = 36'sd983040;
            3'd3:       v = 36'sd1966080;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [35:0] beta_c(input logic [2:0] leg);
        logic signed [35:0] v;
        case (leg)
            3'd1, 3'd2: v = 36'sd929887697;
            3'd4, 3'd5: v = -36'sd929887697;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [35:0] beta_s(input logic [2:0] leg);
        logic signed [35:0] v;
        case (leg)
            3'd0:       v = -36'sd1073741824;
            3'd1, 3'd5: v = -36'sd536870912;
            3'd2, 3'd4: v = 36'sd536870912;
            3'd3:       v = 36'sd1073741824;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/slas_if.sv -----
// ----------------------------------------------------------------------------
// slas_if
// Command and result channels of the leg angle stepper.
// ----------------------------------------------------------------------------
interface slas_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       step_up;
    logic       coarse;

    modport source(output valid, command, step_up, coarse, input ready);
    modport sink(input valid, command, step_up, coarse, output ready);
endinterface

interface slas_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pos_servo0;
    logic [15:0] pos_servo1;
    logic [15:0] pos_servo2;
    logic [15:0] pos_servo3;
    logic [15:0] pos_servo4;
    logic [15:0] pos_servo5;
    logic [2:0]  status;
    logic [2:0]  failed_servo;

    modport source(output valid, pos_servo0, pos_servo1, pos_servo2, pos_servo3,
                   pos_servo4, pos_servo5, status, failed_servo, input ready);
    modport sink(input valid, pos_servo0, pos_servo1, pos_servo2, pos_servo3,
                 pos_servo4, pos_servo5, status, failed_servo, output ready);
endinterface

// ----- src/slas_cordic.sv -----
// ----------------------------------------------------------------------------
// slas_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module slas_cordic #(
    parameter int STEPS = slas_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  slas_pkg::t_cordic_ctl  i_ctl,
    input  logic signed [39:0]     i_x,
    input  logic signed [39:0]     i_y,
    input  logic signed [39:0]     i_z,
    output logic                   o_done,
    output logic signed [39:0]     o_x,
    output logic signed [39:0]     o_y,
    output logic signed [39:0]     o_z
);
    import slas_pkg::*;

    localparam int IT_W = $clog2(STEPS);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(STEPS - 1);

    logic                r_busy;
    logic                r_done;
    logic                r_vec;
    logic [IT_W-1:0]     r_it;
    logic signed [39:0]  r_x;
    logic signed [39:0]  r_y;
    logic signed [39:0]  r_z;
    logic signed [39:0]  w_xs;
    logic signed [39:0]  w_ys;
    logic signed [39:0]  w_a;
    logic                w_ccw;

    always_comb begin
        w_xs  = r_x >>> r_it;
        w_ys  = r_y >>> r_it;
        w_a   = atan_entry(5'(r_it));
        // vectoring drives y toward zero, rotation drives z toward zero
        w_ccw = r_vec ? r_y[39] : ~r_z[39];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_ctl.start && (r_it == LAST_IT);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_vec  <= i_ctl.vector;
                r_it   <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
            end else if (r_busy) begin
                if (w_ccw) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_a;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_a;
                end
                if (r_it == LAST_IT) begin
                    r_busy <= 1'b0;
                end else begin
                    r_it <= r_it + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ----- src/stewart_leg_angle_stepper_core.sv -----
// ----------------------------------------------------------------------------
// stewart_leg_angle_stepper_core
// Pitch/roll stepper for a six-leg rotary Stewart platform.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per beat: home, step pitch or step roll. Each
//   command gives exactly one beat on o_res with the six servo positions
//   after the command, a status code and the index of the rejecting servo.
//   Limits and step sizes sit in an APB register file, written while idle.
// Sequence:
//   Home and the unused code go straight to the result. A step solves the
//   six legs in turn on one multiplier, one 64-bit accumulator and one
//   iterative CORDIC unit: two rotation passes and the shared matrix terms
//   first, then per leg the dot products, a square root and two vectoring
//   passes. A reject ends the pass at the failing leg. One command is in
//   flight at a time.
// Reset:
//   Pose and positions return home, then a boot pass solves the zero pose
//   to get the reference angles; i_cmd.ready stays low until it ends.
//   Registers accept writes throughout.
// Back-pressure:
//   The result waits in an output register; a new command may be accepted
//   meanwhile, and its result waits until the previous beat is taken.
// ----------------------------------------------------------------------------
module stewart_leg_angle_stepper_core #(
    parameter int CORDIC_STEPS = slas_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    slas_cmd_if.sink                     i_cmd,
    slas_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slas_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import slas_pkg::*;

    typedef enum logic [3:0] {
        S_BOOT, S_IDLE, S_SC_START, S_SC_WAIT, S_DOT, S_FIN, S_SQRT,
        S_AT_START, S_AT_WAIT, S_NEXT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_R1, OP_R2, OP_R7, OP_R8, OP_LX, OP_LY, OP_LZ, OP_L, OP_M,
        OP_NB, OP_N, OP_RR, OP_LL, OP_POS
    } t_op;

    t_state r_state;
    t_op    r_op;

    // registers
    logic [15:0] r_low, r_high, r_move;
    logic [11:0] r_fine, r_coarse;

    // architectural state
    logic signed [15:0] r_pitch, r_roll;
    logic [15:0]        r_pos [LEG_COUNT];

    // work registers
    logic                r_zero;
    logic                r_phase;
    logic                r_flip;
    logic [2:0]          r_leg;
    logic [4:0]          r_k;
    logic signed [15:0]  r_th, r_ph;
    logic signed [63:0]  r_acc, r_prod, r_rr;
    logic signed [35:0]  r_ct, r_st, r_cp, r_sp, r_r1, r_r2, r_r7, r_r8;
    logic signed [35:0]  r_lx, r_ly, r_lz, r_l, r_m, r_t, r_n, r_d;
    logic [63:0]         r_sq_v, r_sq_r, r_sq_bit;
    logic signed [39:0]  r_a1;
    logic signed [39:0]  r_za [LEG_COUNT];
    logic [15:0]         r_newpos [LEG_COUNT];
    logic [2:0]          r_status, r_failed;

    t_cordic_ctl         r_cor_ctl;
    logic signed [39:0]  r_cor_x, r_cor_y, r_cor_z;
    logic                w_cor_done;
    logic signed [39:0]  w_cor_x, w_cor_y, w_cor_z;

    logic                r_res_valid;
    logic [15:0]         r_res_pos [LEG_COUNT];
    logic [2:0]          r_res_status, r_res_failed;

    // combinational helpers
    logic                w_accept;
    logic [11:0]         w_step;
    logic signed [15:0]  w_base;
    logic signed [16:0]  w_sum;
    logic signed [15:0]  w_sat;
    logic signed [15:0]  w_ang;
    logic signed [39:0]  w_zin;
    logic signed [35:0]  w_opa, w_opb;
    logic [4:0]          w_terms;
    logic signed [63:0]  w_mul;
    logic signed [63:0]  w_sh30, w_sh18, w_lsh, w_possh;
    logic signed [20:0]  w_newp, w_diff, w_adiff;
    logic [63:0]         w_try;
    logic signed [39:0]  w_cx, w_cy, w_alpha, w_d;

    slas_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_cor_ctl),
        .i_x    (r_cor_x),
        .i_y    (r_cor_y),
        .i_z    (r_cor_z),
        .o_done (w_cor_done),
        .o_x    (w_cor_x),
        .o_y    (w_cor_y),
        .o_z    (w_cor_z)
    );

    assign w_accept    = i_cmd.valid & i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // tentative angle with saturation to Q2.13
    always_comb begin
        w_step = i_cmd.coarse ? r_coarse : r_fine;
        w_base = (i_cmd.command == CMD_PITCH) ? r_pitch : r_roll;
        if (i_cmd.step_up) begin
            w_sum = 17'(w_base) + $signed({5'b0, w_step});
        end else begin
            w_sum = 17'(w_base) - $signed({5'b0, w_step});
        end
        if (w_sum > 17'sd32767) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -17'sd32768) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    // angle into the rotation CORDIC, scaled to Q30; S_SC_START folds it into +-pi/2
    always_comb begin
        w_ang = r_phase ? r_ph : r_th;
        w_zin = $signed({{7{w_ang[15]}}, w_ang, 17'b0});
    end

    // operand select of the dot-product steps
    always_comb begin
        w_opa   = '0;
        w_opb   = '0;
        w_terms = 5'd1;
        case (r_op)
            OP_R1: begin w_opa = r_st; w_opb = r_sp; end
            OP_R2: begin w_opa = r_st; w_opb = r_cp; end
            OP_R7: begin w_opa = r_ct; w_opb = r_sp; end
            OP_R8: begin w_opa = r_ct; w_opb = r_cp; end
            OP_LX: begin
                w_terms = 5'd3;
                case (r_k)
                    5'd0:    begin w_opa = r_ct; w_opb = plat_x(r_leg); end
                    5'd1:    begin w_opa = r_r1; w_opb = plat_y(r_leg); end
                    5'd2:    begin w_opa = r_r2; w_opb = PLAT_Z; end
                    default: ;
                endcase
            end
            OP_LY: begin
                w_terms = 5'd2;
                case (r_k)
                    5'd0:    begin w_opa = r_cp;  w_opb = plat_y(r_leg); end
                    5'd1:    begin w_opa = -r_sp; w_opb = PLAT_Z; end
                    default: ;
                endcase
            end
            OP_LZ: begin
                w_terms = 5'd3;
                case (r_k)
                    5'd0:    begin w_opa = -r_st; w_opb = plat_x(r_leg); end
                    5'd1:    begin w_opa = r_r7;  w_opb = plat_y(r_leg); end
                    5'd2:    begin w_opa = r_r8;  w_opb = PLAT_Z; end
                    default: ;
                endcase
            end
            OP_L: begin
                w_terms = 5'd3;
                case (r_k)
                    5'd0:    begin w_opa = r_lx; w_opb = r_lx; end
                    5'd1:    begin w_opa = r_ly; w_opb = r_ly; end
                    5'd2:    begin w_opa = r_lz; w_opb = r_lz; end
                    default: ;
                endcase
            end
            OP_M: begin w_opa = TWO_HORN; w_opb = r_lz; end
            OP_NB: begin
                w_terms = 5'd2;
                case (r_k)
                    5'd0:    begin w_opa = beta_c(r_leg); w_opb = r_lx; end
                    5'd1:    begin w_opa = beta_s(r_leg); w_opb = r_ly; end
                    default: ;
                endcase
            end
            OP_N: begin w_opa = TWO_HORN; w_opb = r_t; end
            OP_RR: begin
                w_terms = 5'd2;
                case (r_k)
                    5'd0:    begin w_opa = r_m; w_opb = r_m; end
                    5'd1:    begin w_opa = r_n; w_opb = r_n; end
                    default: ;
                endcase
            end
            OP_LL:  begin w_opa = r_l; w_opb = r_l; end
            OP_POS: begin w_opa = r_d; w_opb = POS_MUL; end
            default: ;
        endcase
        if (r_k >= w_terms) begin
            w_opa = '0;
            w_opb = '0;
        end
    end

    assign w_mul = w_opa * w_opb;

    // post-processing of the accumulator
    always_comb begin
        w_sh30  = r_acc >>> 30;
        w_sh18  = r_acc >>> 18;
        w_lsh   = (r_acc - LEG_SQ) >>> 18;
        w_possh = (r_acc + POS_ROUND) >>> 40;
        w_newp  = $signed(w_possh[20:0]) + 21'sd32768;
        w_diff  = w_newp - $signed({5'b0, r_pos[r_leg]});
        w_adiff = w_diff[20] ? -w_diff : w_diff;
        w_try   = r_sq_r + r_sq_bit;
        w_cx    = r_flip ? -w_cor_x : w_cor_x;
        w_cy    = r_flip ? -w_cor_y : w_cor_y;
        w_alpha = r_a1 - w_cor_z;
        // servos 0, 2 and 4 are mirrored
        w_d     = r_leg[0] ? (w_alpha - r_za[r_leg]) : (r_za[r_leg] - w_alpha);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_op        <= OP_R1;
            r_res_valid <= 1'b0;
            r_cor_ctl   <= '0;
            r_low       <= LOW_RST;
            r_high      <= HIGH_RST;
            r_move      <= MOVE_RST;
            r_fine      <= FINE_RST;
            r_coarse    <= COARSE_RST;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_zero      <= 1'b0;
            r_phase     <= 1'b0;
            r_leg       <= '0;
            r_k         <= '0;
            for (int i = 0; i < LEG_COUNT; i++) begin
                r_pos[i] <= MID_POS;
            end
        end else begin
            // start pulse for one cycle after a start state
            r_cor_ctl.start  <= (r_state == S_SC_START) || (r_state == S_AT_START);
            r_cor_ctl.vector <= (r_state == S_AT_START);

            if (psel && penable && pwrite) begin
                case (paddr[ADDR_W-1:2])
                    REG_LOW:    r_low    <= pwdata[15:0];
                    REG_HIGH:   r_high   <= pwdata[15:0];
                    REG_MOVE:   r_move   <= pwdata[15:0];
                    REG_FINE:   r_fine   <= pwdata[11:0];
                    REG_COARSE: r_coarse <= pwdata[11:0];
                    default: ;
                endcase
            end

            if (r_state == S_DONE && (!r_res_valid || o_res.ready)) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end

            case (r_state)
                S_BOOT: begin
                    r_zero  <= 1'b1;
                    r_th    <= '0;
                    r_ph    <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_SC_START;
                end

                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= STAT_OK;
                        r_failed <= '0;
                        r_phase  <= 1'b0;
                        case (i_cmd.command)
                            CMD_HOME: begin
                                r_pitch <= '0;
                                r_roll  <= '0;
                                for (int i = 0; i < LEG_COUNT; i++) begin
                                    r_pos[i] <= MID_POS;
                                end
                                r_state <= S_DONE;
                            end
                            CMD_PITCH: begin
                                r_th    <= w_sat;
                                r_ph    <= r_roll;
                                r_state <= S_SC_START;
                            end
                            CMD_ROLL: begin
                                r_th    <= r_pitch;
                                r_ph    <= w_sat;
                                r_state <= S_SC_START;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end

                S_SC_START: begin
                    r_cor_x <= CORDIC_KINV;
                    r_cor_y <= '0;
                    if (w_zin > Q30_HALF_PI) begin
                        r_cor_z <= w_zin - Q30_PI;
                        r_flip  <= 1'b1;
                    end else if (w_zin < -Q30_HALF_PI) begin
                        r_cor_z <= w_zin + Q30_PI;
                        r_flip  <= 1'b1;
                    end else begin
                        r_cor_z <= w_zin;
                        r_flip  <= 1'b0;
                    end
                    r_state <= S_SC_WAIT;
                end

                S_SC_WAIT: begin
                    if (w_cor_done) begin
                        if (!r_phase) begin
                            r_ct    <= w_cx[35:0];
                            r_st    <= w_cy[35:0];
                            r_phase <= 1'b1;
                            r_state <= S_SC_START;
                        end else begin
                            r_cp    <= w_cx[35:0];
                            r_sp    <= w_cy[35:0];
                            r_leg   <= '0;
                            r_op    <= OP_R1;
                            r_k     <= '0;
                            r_state <= S_DOT;
                        end
                    end
                end

                // pipelined multiply-accumulate: the product of one beat is summed in the next
                S_DOT: begin
                    r_prod <= w_mul;
                    if (r_k == 5'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (r_k == w_terms) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end

                S_FIN: begin
                    r_k <= '0;
                    case (r_op)
                        OP_R1: begin
                            r_r1 <= w_sh30[35:0]; r_op <= OP_R2; r_state <= S_DOT;
                        end
                        OP_R2: begin
                            r_r2 <= w_sh30[35:0]; r_op <= OP_R7; r_state <= S_DOT;
                        end
                        OP_R7: begin
                            r_r7 <= w_sh30[35:0]; r_op <= OP_R8; r_state <= S_DOT;
                        end
                        OP_R8: begin
                            r_r8 <= w_sh30[35:0]; r_op <= OP_LX; r_state <= S_DOT;
                        end
                        OP_LX: begin
                            r_lx    <= $signed(w_sh30[35:0]) - base_x(r_leg);
                            r_op    <= OP_LY;
                            r_state <= S_DOT;
                        end
                        OP_LY: begin
                            r_ly    <= $signed(w_sh30[35:0]) - base_y(r_leg);
                            r_op    <= OP_LZ;
                            r_state <= S_DOT;
                        end
                        OP_LZ: begin
                            r_lz    <= $signed(w_sh30[35:0]) + HOME_Z;
                            r_op    <= OP_L;
                            r_state <= S_DOT;
                        end
                        OP_L: begin
                            r_l <= w_lsh[35:0]; r_op <= OP_M; r_state <= S_DOT;
                        end
                        OP_M: begin
                            r_m <= w_sh18[35:0]; r_op <= OP_NB; r_state <= S_DOT;
                        end
                        OP_NB: begin
                            r_t <= w_sh30[35:0]; r_op <= OP_N; r_state <= S_DOT;
                        end
                        OP_N: begin
                            r_n <= w_sh18[35:0]; r_op <= OP_RR; r_state <= S_DOT;
                        end
                        OP_RR: begin
                            r_rr <= r_acc; r_op <= OP_LL; r_state <= S_DOT;
                        end
                        OP_LL: begin
                            if (r_acc > r_rr) begin
                                // no solution: asin argument beyond one
                                if (r_zero) begin
                                    r_za[r_leg] <= '0;
                                    r_state     <= S_NEXT;
                                end else begin
                                    r_status <= STAT_UNREACH;
                                    r_failed <= r_leg;
                                    r_state  <= S_DONE;
                                end
                            end else begin
                                r_sq_v   <= r_rr - r_acc;
                                r_sq_r   <= '0;
                                r_sq_bit <= 64'd1 << 62;
                                r_phase  <= 1'b0;
                                r_state  <= S_SQRT;
                            end
                        end
                        OP_POS: begin
                            if (w_adiff > $signed({5'b0, r_move})) begin
                                r_status <= STAT_DRASTIC;
                                r_failed <= r_leg;
                                r_state  <= S_DONE;
                            end else if (w_newp < $signed({5'b0, r_low})) begin
                                r_status <= STAT_LOW;
                                r_failed <= r_leg;
                                r_state  <= S_DONE;
                            end else if (w_newp > $signed({5'b0, r_high})) begin
                                r_status <= STAT_HIGH;
                                r_failed <= r_leg;
                                r_state  <= S_DONE;
                            end else begin
                                r_newpos[r_leg] <= w_newp[15:0];
                                r_state         <= S_NEXT;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end

                // restoring square root, two radicand bits per beat
                S_SQRT: begin
                    if (r_sq_v >= w_try) begin
                        r_sq_v <= r_sq_v - w_try;
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_k      <= r_k + 5'd1;
                    if (r_k == 5'd31) begin
                        r_state <= S_AT_START;
                    end
                end

                S_AT_START: begin
                    r_cor_z <= '0;
                    if (!r_phase) begin
                        r_cor_x <= $signed(r_sq_r[39:0]);
                        r_cor_y <= 40'(r_l);
                    end else begin
                        r_cor_x <= 40'(r_m);
                        r_cor_y <= 40'(r_n);
                    end
                    r_state <= S_AT_WAIT;
                end

                S_AT_WAIT: begin
                    if (w_cor_done) begin
                        if (!r_phase) begin
                            r_a1    <= w_cor_z;
                            r_phase <= 1'b1;
                            r_state <= S_AT_START;
                        end else if (r_zero) begin
                            r_za[r_leg] <= w_alpha;
                            r_state     <= S_NEXT;
                        end else begin
                            r_d     <= w_d[35:0];
                            r_op    <= OP_POS;
                            r_k     <= '0;
                            r_state <= S_DOT;
                        end
                    end
                end

                S_NEXT: begin
                    if (r_leg == 3'(LEG_COUNT - 1)) begin
                        if (r_zero) begin
                            r_zero  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pitch <= r_th;
                            r_roll  <= r_ph;
                            for (int i = 0; i < LEG_COUNT; i++) begin
                                r_pos[i] <= r_newpos[i];
                            end
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_leg   <= r_leg + 3'd1;
                        r_op    <= OP_LX;
                        r_k     <= '0;
                        r_state <= S_DOT;
                    end
                end

                S_DONE: begin
                    if (!r_res_valid || o_res.ready) begin
                        r_res_status <= r_status;
                        r_res_failed <= r_failed;
                        for (int i = 0; i < LEG_COUNT; i++) begin
                            r_res_pos[i] <= r_pos[i];
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.pos_servo0   = r_res_pos[0];
    assign o_res.pos_servo1   = r_res_pos[1];
    assign o_res.pos_servo2   = r_res_pos[2];
    assign o_res.pos_servo3   = r_res_pos[3];
    assign o_res.pos_servo4   = r_res_pos[4];
    assign o_res.pos_servo5   = r_res_pos[5];
    assign o_res.status       = r_res_status;
    assign o_res.failed_servo = r_res_failed;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_LOW:    prdata = {16'b0, r_low};
            REG_HIGH:   prdata = {16'b0, r_high};
            REG_MOVE:   prdata = {16'b0, r_move};
            REG_FINE:   prdata = {20'b0, r_fine};
            REG_COARSE: prdata = {20'b0, r_coarse};
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- dv/stewart_leg_angle_stepper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stewart_leg_angle_stepper_core_test
// Self-checking bench for the pitch/roll stepper of the rotary Stewart platform.
// Commands go in over a valid/ready channel in random bursts, with the result
// channel stalled on its own pattern. Each result is compared field by field
// against a fixed-point inverse-kinematics predictor kept in this file. The run
// walks several register settings (defaults, wide open, zero move, inverted
// limits, a narrow window), each written over APB while the block is idle.
// ----------------------------------------------------------------------------
module stewart_leg_angle_stepper_core_test;
    import slas_pkg::*;

    localparam int  NSTEPS      = 16;
    localparam int  RAND_PER_PH = 24;
    localparam int  NPHASE      = 5;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef longint t_leg6[6];

    typedef struct {
        logic [15:0] pos[6];
        logic [2:0]  status;
        logic [2:0]  failed;
    } t_servo_res;

    typedef struct {
        logic [1:0] command;
        logic       step_up;
        logic       coarse;
        bit         at_home;    // result known: every servo mid, status ok
    } t_cmd_row;

    typedef struct {
        logic [15:0] low;
        logic [15:0] high;
        logic [15:0] move;
        logic [11:0] fine;
        logic [11:0] coarse;
    } t_cfg;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    slas_cmd_if cmd_ch();
    slas_res_if res_ch();

    stewart_leg_angle_stepper_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    const longint arctan_q30[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    const longint anchor_bx[6] = '{0, 4043571, 4043571, 0, -4043571, -4043571};
    const longint anchor_by[6] = '{-4669440, -2334720, 2334720, 4669440, 2334720,
                                   -2334720};
    const longint anchor_px[6] = '{0, 1702625, 1702625, 0, -1702625, -1702625};
    const longint anchor_py[6] = '{-1966080, -983040, 983040, 1966080, 983040,
                                   -983040};
    const longint horn_cos[6] = '{0, 929887697, 929887697, 0, -929887697, -929887697};
    const longint horn_sin[6] = '{-1073741824, -536870912, 536870912, 1073741824,
                                  536870912, -536870912};
    localparam longint PLAT_DZ = -622592;
    localparam longint Z_HOME  = 9568256;
    localparam longint HORN    = 1623982;
    localparam longint ROD     = 9502720;
    localparam longint PI_Q30  = 3373259426;
    localparam longint HPI_Q30 = 1686629713;
    localparam longint KINV    = 652032874;
    localparam longint RAD2POS = 21361415;

    t_cfg        cfg;
    shortint     pitch_q13, roll_q13;
    logic [15:0] servo_now[6];
    t_leg6       home_alpha;

    task automatic rot_sincos(input longint a13, output longint c, output longint s);
        longint z, x, y, t;
        bit flip;
        z = a13 * 131072; x = KINV; y = 0; flip = 0;
        if (z > HPI_Q30) begin
            z -= PI_Q30; flip = 1;
        end else if (z < -HPI_Q30) begin
            z += PI_Q30; flip = 1;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); z -= arctan_q30[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); z += arctan_q30[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint vec_atan2(input longint y, input longint x);
        longint z, t;
        z = 0;
        for (int i = 0; i < NSTEPS; i++) begin
            if (y >= 0) begin
                t = x + (y >>> i); y = y - (x >>> i); z += arctan_q30[i];
            end else begin
                t = x - (y >>> i); y = y + (x >>> i); z -= arctan_q30[i];
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic leg_angles(input longint th, input longint ph,
                              output t_leg6 alpha, output bit reach[6]);
        longint ct, st, cp, sp, r[9];
        longint leg_sq, lx, ly, lz, l, m, n, rr, ll, h;
        leg_sq = ROD * ROD - HORN * HORN;
        rot_sincos(th, ct, st);
        rot_sincos(ph, cp, sp);
        r[0] = ct;  r[1] = (st * sp) >>> 30; r[2] = (st * cp) >>> 30;
        r[3] = 0;   r[4] = cp;               r[5] = -sp;
        r[6] = -st; r[7] = (ct * sp) >>> 30; r[8] = (ct * cp) >>> 30;
        for (int i = 0; i < 6; i++) begin
            lx = ((r[0] * anchor_px[i] + r[1] * anchor_py[i] + r[2] * PLAT_DZ) >>> 30)
                 - anchor_bx[i];
            ly = ((r[3] * anchor_px[i] + r[4] * anchor_py[i] + r[5] * PLAT_DZ) >>> 30)
                 - anchor_by[i];
            lz = ((r[6] * anchor_px[i] + r[7] * anchor_py[i] + r[8] * PLAT_DZ) >>> 30)
                 + Z_HOME;
            l = (lx * lx + ly * ly + lz * lz - leg_sq) >>> 18;
            m = (2 * HORN * lz) >>> 18;
            n = (2 * HORN * ((horn_cos[i] * lx + horn_sin[i] * ly) >>> 30)) >>> 18;
            rr = m * m + n * n;
            ll = l * l;
            if (ll > rr) begin
                reach[i] = 0; alpha[i] = 0;
            end else begin
                h = longint'(int_sqrt(longint'(rr - ll)));
                alpha[i] = vec_atan2(l, h) - vec_atan2(n, m);
                reach[i] = 1;
            end
        end
    endtask

    function automatic longint clip_q13(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic predictor_reset();
        bit reach[6];
        cfg = '{LOW_RST, HIGH_RST, MOVE_RST, FINE_RST, COARSE_RST};
        pitch_q13 = 0; roll_q13 = 0;
        foreach (servo_now[i]) servo_now[i] = MID_POS;
        leg_angles(0, 0, home_alpha, reach);
        foreach (reach[i]) if (!reach[i]) home_alpha[i] = 0;
    endtask

    task automatic predict_servos(input logic [1:0] c, input logic up, input logic big,
                                  output t_servo_res res);
        longint step, th, ph, d, dif;
        longint pos[6];
        t_leg6 alpha;
        bit reach[6];
        logic [2:0] st, fl;
        st = STAT_OK; fl = 3'd0;
        if (c == CMD_HOME) begin
            pitch_q13 = 0; roll_q13 = 0;
            foreach (servo_now[i]) servo_now[i] = MID_POS;
        end else if (c == CMD_PITCH || c == CMD_ROLL) begin
            step = big ? cfg.coarse : cfg.fine;
            th = pitch_q13; ph = roll_q13;
            if (c == CMD_PITCH) th = clip_q13(up ? th + step : th - step);
            else                ph = clip_q13(up ? ph + step : ph - step);
            leg_angles(th, ph, alpha, reach);
            for (int i = 0; i < 6; i++) begin
                if (!reach[i]) begin
                    st = STAT_UNREACH; fl = 3'(i); break;
                end
                d = (i % 2 == 0) ? home_alpha[i] - alpha[i] : alpha[i] - home_alpha[i];
                pos[i] = 32768 + ((d * RAD2POS + (64'sd1 <<< 39)) >>> 40);
                dif = pos[i] - longint'(servo_now[i]);
                if (dif < 0) dif = -dif;
                if (dif > longint'(cfg.move)) begin
                    st = STAT_DRASTIC; fl = 3'(i); break;
                end
                if (pos[i] < longint'(cfg.low)) begin
                    st = STAT_LOW; fl = 3'(i); break;
                end
                if (pos[i] > longint'(cfg.high)) begin
                    st = STAT_HIGH; fl = 3'(i); break;
                end
            end
            if (st == STAT_OK) begin
                pitch_q13 = shortint'(th); roll_q13 = shortint'(ph);
                foreach (servo_now[i]) servo_now[i] = pos[i][15:0];
            end
        end
        foreach (servo_now[i]) res.pos[i] = servo_now[i];
        res.status = st;
        res.failed = fl;
    endtask

    // ---------------- checking ----------------
    t_servo_res pending_res[$];
    int errors = 0;
    int status_seen[5];
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_res.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side stall pattern: ready follows one of four modes, redrawn at random
    logic [1:0] stall_mode = 2'd0;
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: res_ch.ready <= 1'b1;
            2'd1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= cycles[3];
        endcase
    end

    always @(posedge i_clk) begin
        t_servo_res want;
        logic [15:0] got_pos[6];
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_pos = '{res_ch.pos_servo0, res_ch.pos_servo1, res_ch.pos_servo2,
                        res_ch.pos_servo3, res_ch.pos_servo4, res_ch.pos_servo5};
            if (pending_res.size() == 0) begin
                $display("%0t: result beat with nothing pending", $time);
                errors++;
            end else begin
                want = pending_res.pop_front();
                for (int i = 0; i < 6; i++)
                    if (got_pos[i] !== want.pos[i]) begin
                        $display("%0t: pos_servo%0d expected %0d got %0d",
                                 $time, i, want.pos[i], got_pos[i]);
                        errors++;
                    end
                if (res_ch.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, res_ch.status);
                    errors++;
                end
                if (res_ch.failed_servo !== want.failed) begin
                    $display("%0t: failed_servo expected %0d got %0d",
                             $time, want.failed, res_ch.failed_servo);
                    errors++;
                end
                if (want.status <= STAT_UNREACH) status_seen[want.status]++;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic load_cfg(input t_cfg c);
        apb_write(REG_LOW, 32'(c.low));
        apb_write(REG_HIGH, 32'(c.high));
        apb_write(REG_MOVE, 32'(c.move));
        apb_write(REG_FINE, 32'(c.fine));
        apb_write(REG_COARSE, 32'(c.coarse));
        cfg = c;
    endtask

    // drive one command beat and hold it until taken; then maybe open a gap
    task automatic send_cmd(input t_cmd_row row);
        t_servo_res res;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= row.command;
        cmd_ch.step_up <= row.step_up;
        cmd_ch.coarse  <= row.coarse;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_servos(row.command, row.step_up, row.coarse, res);
        if (row.at_home) begin
            foreach (res.pos[i]) res.pos[i] = MID_POS;
            res.status = STAT_OK; res.failed = 3'd0;
        end
        pending_res.push_back(res);
        if ($urandom_range(0, 2) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    const t_cmd_row directed[] = '{
        '{CMD_HOME,  1'b0, 1'b0, 1},
        '{CMD_SPARE, 1'b1, 1'b1, 1},
        '{CMD_PITCH, 1'b1, 1'b0, 0},
        '{CMD_PITCH, 1'b1, 1'b1, 0},
        '{CMD_PITCH, 1'b1, 1'b1, 0},
        '{CMD_PITCH, 1'b1, 1'b1, 0},
        '{CMD_PITCH, 1'b1, 1'b1, 0},
        '{CMD_SPARE, 1'b0, 1'b0, 0},
        '{CMD_PITCH, 1'b0, 1'b0, 0},
        '{CMD_HOME,  1'b1, 1'b1, 1},
        '{CMD_ROLL,  1'b1, 1'b0, 0},
        '{CMD_ROLL,  1'b1, 1'b1, 0},
        '{CMD_ROLL,  1'b1, 1'b1, 0},
        '{CMD_ROLL,  1'b1, 1'b1, 0},
        '{CMD_ROLL,  1'b0, 1'b1, 0},
        '{CMD_PITCH, 1'b0, 1'b1, 0},
        '{CMD_PITCH, 1'b0, 1'b1, 0},
        '{CMD_PITCH, 1'b0, 1'b1, 0},
        '{CMD_ROLL,  1'b0, 1'b0, 0},
        '{CMD_HOME,  1'b0, 1'b1, 1}
    };

    const t_cfg phase_cfg[NPHASE] = '{
        '{16'd6554,  16'd58982, 16'd13107, 12'd286,  12'd858},
        '{16'd0,     16'd65535, 16'd65535, 12'd4095, 12'd4095},
        '{16'd0,     16'd65535, 16'd0,     12'd0,    12'd1},
        '{16'd40000, 16'd20000, 16'd65535, 12'd286,  12'd858},
        '{16'd20000, 16'd45000, 16'd5000,  12'd100,  12'd2000}
    };

    initial begin
        t_cmd_row row;
        int pick;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        cmd_ch.valid <= 1'b0; cmd_ch.command <= CMD_HOME;
        cmd_ch.step_up <= 1'b0; cmd_ch.coarse <= 1'b0;
        predictor_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_cmd(directed[k]);
        drain();

        for (int p = 0; p < NPHASE; p++) begin
            load_cfg(phase_cfg[p]);
            for (int k = 0; k < RAND_PER_PH; k++) begin
                pick = $urandom_range(0, 19);
                row.command = (pick < 2) ? CMD_HOME : (pick == 2) ? CMD_SPARE :
                              (pick < 11) ? CMD_PITCH : CMD_ROLL;
                row.step_up = 1'($urandom_range(0, 1));
                row.coarse  = 1'($urandom_range(0, 1));
                row.at_home = 0;
                send_cmd(row);
            end
            drain();
        end

        repeat (800) @(posedge i_clk);
        $display("Covered %0d directed and %0d random commands over %0d register sets.",
                 directed.size(), NPHASE * RAND_PER_PH, NPHASE);
        $display("Status mix ok/drastic/low/high/unreach: %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
